### hdl/wsd_pkg.sv
// shared types and constants for the websocket frame deframer
`default_nettype none

package wsd_pkg;

  // parse phase, one-hot
  typedef enum logic [4:0] {
    PH_HDR0    = 5'b00001,
    PH_HDR1    = 5'b00010,
    PH_EXT     = 5'b00100,
    PH_MASK    = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [2:0] KIND_TEXT   = 3'd0;
  localparam logic [2:0] KIND_EMPTY  = 3'd1;
  localparam logic [2:0] KIND_PING   = 3'd2;
  localparam logic [2:0] KIND_CLOSE  = 3'd3;
  localparam logic [2:0] KIND_MASKED = 3'd4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] close_code;
    logic [7:0]  data;
    logic        last;
  } wsd_res_t;

endpackage

`default_nettype wire

### hdl/wsd_parse.sv
// frame parser state machine: one received byte per accepted transaction
`default_nettype none

module wsd_parse (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic [7:0]       rx_byte,
  output logic                  res_valid,
  output wsd_pkg::wsd_res_t     res
);

  wsd_pkg::phase_t phase, phase_next;
  logic [2:0]  byte_count, byte_count_next;
  logic        frame_fin, frame_fin_next;
  logic [3:0]  frame_opcode, frame_opcode_next;
  logic        frame_masked, frame_masked_next;
  logic [63:0] remaining_length, remaining_length_next;
  logic        msg_text, msg_text_next;
  logic [15:0] code_acc, code_acc_next;
  logic [1:0]  ctrl_idx, ctrl_idx_next;

  logic after_req, begin_req, fin_req, empty_req;

  function automatic logic is_text(input logic masked, input logic [3:0] op,
                                   input logic text_msg);
    is_text = !masked && (op == wsd_pkg::OP_TEXT ||
                          (op == wsd_pkg::OP_CONT && text_msg));
  endfunction

  always_comb begin
    phase_next            = phase;
    byte_count_next       = byte_count;
    frame_fin_next        = frame_fin;
    frame_opcode_next     = frame_opcode;
    frame_masked_next     = frame_masked;
    remaining_length_next = remaining_length;
    msg_text_next         = msg_text;
    code_acc_next         = code_acc;
    ctrl_idx_next         = ctrl_idx;
    after_req             = 1'b0;
    begin_req             = 1'b0;
    fin_req               = 1'b0;
    empty_req             = 1'b0;
    res_valid             = 1'b0;
    res                   = '0;

    case (phase)
      wsd_pkg::PH_HDR1: begin
        frame_masked_next = rx_byte[7];
        remaining_length_next = '0;
        if (rx_byte[6:0] == wsd_pkg::LEN_EXT16) begin
          phase_next      = wsd_pkg::PH_EXT;
          byte_count_next = 3'd1;
        end else if (rx_byte[6:0] == wsd_pkg::LEN_EXT64) begin
          phase_next      = wsd_pkg::PH_EXT;
          byte_count_next = 3'd7;
        end else begin
          remaining_length_next = {57'd0, rx_byte[6:0]};
          after_req = 1'b1;
        end
      end
      wsd_pkg::PH_EXT: begin
        remaining_length_next = {remaining_length[55:0], rx_byte};
        if (byte_count == 3'd0) begin
          after_req = 1'b1;
        end else begin
          byte_count_next = byte_count - 3'd1;
        end
      end
      wsd_pkg::PH_MASK: begin
        if (byte_count == 3'd0) begin
          begin_req = 1'b1;
        end else begin
          byte_count_next = byte_count - 3'd1;
        end
      end
      wsd_pkg::PH_PAYLOAD: begin
        remaining_length_next = remaining_length - 64'd1;
        if (is_text(frame_masked, frame_opcode, msg_text)) begin
          res_valid = 1'b1;
          res.kind  = wsd_pkg::KIND_TEXT;
          res.data  = rx_byte;
          res.last  = (remaining_length_next == 64'd0) && frame_fin;
        end else if (!frame_masked && frame_opcode == wsd_pkg::OP_CLOSE) begin
          // big-endian close code from the first two payload bytes
          if (ctrl_idx == 2'd0) begin
            code_acc_next = {rx_byte, 8'h00};
            ctrl_idx_next = 2'd1;
          end else if (ctrl_idx == 2'd1) begin
            code_acc_next = {code_acc[15:8], rx_byte};
            ctrl_idx_next = 2'd2;
          end
        end
        fin_req = (remaining_length_next == 64'd0);
      end
      default: begin
        frame_fin_next    = rx_byte[7];
        frame_opcode_next = rx_byte[3:0];
        phase_next        = wsd_pkg::PH_HDR1;
      end
    endcase

    // length complete: mask key follows, else payload starts or the frame ends
    if (after_req) begin
      if (frame_masked_next) begin
        phase_next      = wsd_pkg::PH_MASK;
        byte_count_next = 3'd3;
      end else begin
        begin_req = 1'b1;
      end
    end

    if (begin_req) begin
      if (!frame_masked_next) begin
        if (frame_opcode_next == wsd_pkg::OP_TEXT) begin
          msg_text_next = 1'b1;
        end else if (frame_opcode_next == wsd_pkg::OP_BINARY) begin
          msg_text_next = 1'b0;
        end
      end
      code_acc_next = '0;
      ctrl_idx_next = '0;
      if (remaining_length_next != 64'd0) begin
        phase_next = wsd_pkg::PH_PAYLOAD;
      end else begin
        empty_req = is_text(frame_masked_next, frame_opcode_next, msg_text_next) &&
                    frame_fin_next;
        fin_req = 1'b1;
      end
    end

    // frame fully consumed
    if (fin_req) begin
      phase_next = wsd_pkg::PH_HDR0;
      if (frame_masked_next) begin
        res_valid = 1'b1;
        res       = '0;
        res.kind  = wsd_pkg::KIND_MASKED;
      end else begin
        if (frame_opcode_next <= wsd_pkg::OP_BINARY && frame_fin_next) begin
          msg_text_next = 1'b0;
        end
        if (frame_opcode_next == wsd_pkg::OP_PING) begin
          res_valid = 1'b1;
          res       = '0;
          res.kind  = wsd_pkg::KIND_PING;
        end else if (frame_opcode_next == wsd_pkg::OP_CLOSE) begin
          res_valid      = 1'b1;
          res            = '0;
          res.kind       = wsd_pkg::KIND_CLOSE;
          res.close_code = (ctrl_idx_next == 2'd2) ? code_acc_next : 16'd0;
        end
      end
    end

    if (empty_req) begin
      res_valid = 1'b1;
      res       = '0;
      res.kind  = wsd_pkg::KIND_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= wsd_pkg::PH_HDR0;
      byte_count       <= '0;
      frame_fin        <= 1'b0;
      frame_opcode     <= '0;
      frame_masked     <= 1'b0;
      remaining_length <= '0;
      msg_text         <= 1'b0;
      code_acc         <= '0;
      ctrl_idx         <= '0;
    end else if (en) begin
      phase            <= phase_next;
      byte_count       <= byte_count_next;
      frame_fin        <= frame_fin_next;
      frame_opcode     <= frame_opcode_next;
      frame_masked     <= frame_masked_next;
      remaining_length <= remaining_length_next;
      msg_text         <= msg_text_next;
      code_acc         <= code_acc_next;
      ctrl_idx         <= ctrl_idx_next;
    end
  end

`ifndef SYNTHESIS
  a_data_only_text: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind != wsd_pkg::KIND_TEXT |-> res.data == 8'd0 && !res.last)
    else $error("non-text event carries data or last");
  a_code_only_close: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind != wsd_pkg::KIND_CLOSE |-> res.close_code == 16'd0)
    else $error("close code on non-close event");
  a_payload_len: assert property (@(posedge clk) disable iff (rst)
    phase == wsd_pkg::PH_PAYLOAD |-> remaining_length != 64'd0)
    else $error("payload phase with zero length left");
`endif

endmodule

`default_nettype wire

### hdl/websocket_frame_deframer.sv
// websocket frame deframer top level: byte input stream, event output stream
// usage:
//   s_axis carries the received connection stream, one byte per transaction
//   in tdata. m_axis carries events: tuser is the event kind (text byte,
//   empty text message, ping seen, close seen, masked frame dropped), tdata
//   holds the payload byte and the close code, tlast marks the final byte
//   of a text message.
//   each byte is parsed in the cycle it is accepted; an event it causes is
//   registered for m_axis. throughput is one byte per cycle while
//   s_axis_tready is high, set by the single parse step on the 64-bit
//   length counter; most bytes (headers, binary payload) give no event.
//   the output holds one event plus one skid entry; when the receiver stalls
//   and both are full, s_axis_tready drops until the skid entry drains.
//   after reset the parser expects the first header byte of a frame, no
//   message is open and the output is empty.
`default_nettype none

module websocket_frame_deframer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // rx_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // data [7:0], close_code [23:8]
  output logic             m_axis_tlast,   // last
  output logic [2:0]       m_axis_tuser    // kind
);

  logic              accept;
  logic              res_valid;
  wsd_pkg::wsd_res_t res;

  logic              out_valid;
  wsd_pkg::wsd_res_t out_res;
  logic              skid_valid;
  wsd_pkg::wsd_res_t skid_res;
  logic              pop;
  logic              push;

  assign s_axis_tready = !skid_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pop           = out_valid && m_axis_tready;
  assign push          = accept && res_valid;

  wsd_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .en        (accept),
    .rx_byte   (s_axis_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_res   <= res;
        out_valid <= 1'b1;
      end else begin
        skid_res   <= res;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_res.close_code, out_res.data};
  assign m_axis_tlast  = out_res.last;
  assign m_axis_tuser  = out_res.kind;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !m_axis_tready))
    else $error("skid filled while output register was free");
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    $fell(skid_valid) |-> $past(m_axis_tready))
    else $error("skid drained without an output transaction");
`endif

endmodule

`default_nettype wire

### verif/wsd_event_checker.sv
// event checker for the websocket frame deframer: predicts events per byte and compares
`default_nettype none

module wsd_event_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [7:0]  s_tdata,   // rx_byte
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [23:0] m_tdata,   // data [7:0], close_code [23:8]
  input  wire logic        m_tlast,   // last
  input  wire logic [2:0]  m_tuser,   // kind
  output int               fail_count,
  output int               pending,
  output int               checked,
  output logic [4:0]       kinds_seen
);

  localparam logic [3:0] MSG_NONE = 4'h0;
  localparam int         MAX_REPORTS = 10;

  // parser state mirrored from the byte stream
  wsd_pkg::phase_t st_phase;
  logic [2:0]  hdr_left;
  logic        f_fin;
  logic [3:0]  f_op;
  logic        f_masked;
  logic [63:0] len_left;
  logic [3:0]  msg_op;
  logic [15:0] close_acc;
  logic [1:0]  close_cnt;

  logic              pred_hit;
  wsd_pkg::wsd_res_t pred_ev;
  wsd_pkg::wsd_res_t expected_events[$];
  wsd_pkg::wsd_res_t seen_ev;
  wsd_pkg::wsd_res_t want_ev;
  int                n_fail;
  int                n_checked;

  function automatic void raise(logic [2:0] kind, logic [7:0] data, logic last,
                                logic [15:0] code);
    pred_hit           = 1'b1;
    pred_ev.kind       = kind;
    pred_ev.data       = data;
    pred_ev.last       = last;
    pred_ev.close_code = code;
  endfunction

  function automatic logic carries_text();
    return !f_masked && (f_op == wsd_pkg::OP_TEXT ||
                         (f_op == wsd_pkg::OP_CONT && msg_op == wsd_pkg::OP_TEXT));
  endfunction

  // whole frame consumed
  function automatic void end_frame();
    st_phase = wsd_pkg::PH_HDR0;
    if (f_masked) begin
      raise(wsd_pkg::KIND_MASKED, 8'h00, 1'b0, 16'h0000);
    end else begin
      if (f_op <= wsd_pkg::OP_BINARY && f_fin) msg_op = MSG_NONE;
      if (f_op == wsd_pkg::OP_PING) raise(wsd_pkg::KIND_PING, 8'h00, 1'b0, 16'h0000);
      else if (f_op == wsd_pkg::OP_CLOSE)
        raise(wsd_pkg::KIND_CLOSE, 8'h00, 1'b0,
              (close_cnt == 2'd2) ? close_acc : 16'h0000);
    end
  endfunction

  function automatic void start_payload();
    if (!f_masked && (f_op == wsd_pkg::OP_TEXT || f_op == wsd_pkg::OP_BINARY)) msg_op = f_op;
    close_acc = 16'h0000;
    close_cnt = 2'd0;
    if (len_left != 64'd0) begin
      st_phase = wsd_pkg::PH_PAYLOAD;
    end else if (carries_text() && f_fin) begin
      end_frame();
      raise(wsd_pkg::KIND_EMPTY, 8'h00, 1'b0, 16'h0000);
    end else begin
      end_frame();
    end
  endfunction

  function automatic void length_done();
    if (f_masked) begin
      st_phase = wsd_pkg::PH_MASK;
      hdr_left = 3'd3;
    end else begin
      start_payload();
    end
  endfunction

  function automatic void parse_byte(logic [7:0] b);
    logic done;
    logic is_last;
    case (st_phase)
      wsd_pkg::PH_HDR1: begin
        f_masked = b[7];
        len_left = 64'd0;
        if (b[6:0] == wsd_pkg::LEN_EXT16) begin
          st_phase = wsd_pkg::PH_EXT;
          hdr_left = 3'd1;
        end else if (b[6:0] == wsd_pkg::LEN_EXT64) begin
          st_phase = wsd_pkg::PH_EXT;
          hdr_left = 3'd7;
        end else begin
          len_left = {57'd0, b[6:0]};
          length_done();
        end
      end
      wsd_pkg::PH_EXT: begin
        len_left = {len_left[55:0], b};
        if (hdr_left == 3'd0) length_done();
        else hdr_left = hdr_left - 3'd1;
      end
      wsd_pkg::PH_MASK: begin
        if (hdr_left == 3'd0) start_payload();
        else hdr_left = hdr_left - 3'd1;
      end
      wsd_pkg::PH_PAYLOAD: begin
        len_left = len_left - 64'd1;
        done = (len_left == 64'd0);
        if (carries_text()) begin
          is_last = done && f_fin;
          if (done) end_frame();
          raise(wsd_pkg::KIND_TEXT, b, is_last, 16'h0000);
        end else begin
          // close code is the first two payload bytes, big-endian
          if (!f_masked && f_op == wsd_pkg::OP_CLOSE) begin
            if (close_cnt == 2'd0) begin
              close_acc = {b, 8'h00};
              close_cnt = 2'd1;
            end else if (close_cnt == 2'd1) begin
              close_acc[7:0] = b;
              close_cnt = 2'd2;
            end
          end
          if (done) end_frame();
        end
      end
      default: begin
        f_fin    = b[7];
        f_op     = b[3:0];
        st_phase = wsd_pkg::PH_HDR1;
      end
    endcase
  endfunction

  task automatic report(string why);
    n_fail = n_fail + 1;
    if (n_fail <= MAX_REPORTS)
      $display("mismatch (%s): expected kind %0d data %h last %b code %h, %s",
               why, want_ev.kind, want_ev.data, want_ev.last, want_ev.close_code,
               $sformatf("got kind %0d data %h last %b code %h",
                         seen_ev.kind, seen_ev.data, seen_ev.last, seen_ev.close_code));
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
    kinds_seen = '0;
    n_fail     = 0;
    n_checked  = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      st_phase  = wsd_pkg::PH_HDR0;
      hdr_left  = 3'd0;
      f_fin     = 1'b0;
      f_op      = 4'h0;
      f_masked  = 1'b0;
      len_left  = 64'd0;
      msg_op    = MSG_NONE;
      close_acc = 16'h0000;
      close_cnt = 2'd0;
      expected_events.delete();
      n_fail    = 0;
      n_checked = 0;
      kinds_seen <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        pred_hit = 1'b0;
        parse_byte(s_tdata);
        if (pred_hit) expected_events.push_back(pred_ev);
      end
      if (m_tvalid && m_tready) begin
        seen_ev.kind       = m_tuser;
        seen_ev.data       = m_tdata[7:0];
        seen_ev.close_code = m_tdata[23:8];
        seen_ev.last       = m_tlast;
        n_checked = n_checked + 1;
        if (m_tuser <= wsd_pkg::KIND_MASKED) kinds_seen[m_tuser] <= 1'b1;
        if (expected_events.size() == 0) begin
          want_ev = '0;
          report("no event expected");
        end else begin
          want_ev = expected_events.pop_front();
          if (want_ev !== seen_ev) report("field differs");
        end
      end
    end
    fail_count <= n_fail;
    pending    <= expected_events.size();
    checked    <= n_checked;
  end

endmodule

`default_nettype wire

### verif/tb_websocket_frame_deframer.sv
// testbench top for the websocket frame deframer: frame stimulus, idling phases, verdict
`default_nettype none

module tb_websocket_frame_deframer;

  localparam logic [3:0] OP_RSV_DATA = 4'h3;
  localparam logic [3:0] OP_PONG     = 4'hA;
  localparam logic [3:0] OP_RSV_CTRL = 4'hF;
  localparam int         FILL_RANDOM = -1;
  localparam int         STALL_LIMIT = 2000;
  localparam int         PHASE_BYTES = 360;

  typedef enum int {LEN_ANY, LEN_SHORT, LEN_16, LEN_64} len_enc_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;           // data [7:0], close_code [23:8]
  logic        m_axis_tlast;           // last
  logic [2:0]  m_axis_tuser;           // kind

  int          fail_count;
  int          pending;
  int          checked;
  logic [4:0]  kinds_seen;
  int          src_idle_pct = 0;
  int          snk_stall_pct = 0;
  int          bytes_sent = 0;
  int          stall_cycles = 0;

  websocket_frame_deframer u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  wsd_event_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_axis_tvalid),
    .s_tready   (s_axis_tready),
    .s_tdata    (s_axis_tdata),
    .m_tvalid   (m_axis_tvalid),
    .m_tready   (m_axis_tready),
    .m_tdata    (m_axis_tdata),
    .m_tlast    (m_axis_tlast),
    .m_tuser    (m_axis_tuser),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .kinds_seen (kinds_seen)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", stall_cycles);
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    bytes_sent = bytes_sent + 1;
  endtask

  // sender holds off until every predicted event has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic send_frame(input logic fin, input logic [3:0] op, input logic masked,
                            input logic [63:0] len, input int body, input len_enc_t enc,
                            input int fill);
    len_enc_t use_enc;
    int       r;
    int       i;
    use_enc = enc;
    if (use_enc == LEN_ANY) begin
      r = $urandom_range(99);
      use_enc = (r < 75) ? LEN_SHORT : (r < 90) ? LEN_16 : LEN_64;
    end
    if (use_enc == LEN_SHORT && len > 64'd125) use_enc = LEN_16;
    if (use_enc == LEN_16 && len > 64'd65535) use_enc = LEN_64;
    // reserved bits of the first header byte are random
    send_byte({fin, 3'($urandom_range(7)), op});
    case (use_enc)
      LEN_SHORT: send_byte({masked, len[6:0]});
      LEN_16: begin
        send_byte({masked, wsd_pkg::LEN_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({masked, wsd_pkg::LEN_EXT64});
        for (i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
      end
    endcase
    if (masked) for (i = 0; i < 4; i++) send_byte(8'($urandom_range(255)));
    for (i = 0; i < body; i++)
      send_byte((fill < 0) ? 8'($urandom_range(255)) : 8'(fill));
  endtask

  task automatic frame(input logic fin, input logic [3:0] op, input logic masked,
                       input int len);
    send_frame(fin, op, masked, 64'(len), len, LEN_ANY, FILL_RANDOM);
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 0;
    if (r < 87) return $urandom_range(1, 8);
    if (r < 97) return $urandom_range(9, 40);
    return $urandom_range(200, 300);
  endfunction

  task automatic control_frame();
    int r;
    r = $urandom_range(2);
    frame(1'($urandom_range(1)),
          (r == 0) ? wsd_pkg::OP_PING : (r == 1) ? wsd_pkg::OP_CLOSE : OP_PONG, 1'b0,
          $urandom_range(0, 4));
  endtask

  task automatic random_frame();
    int r;
    int nfrag;
    int i;
    r = $urandom_range(99);
    if (r < 55) begin
      // fragmented data message, control frames may sit between fragments
      nfrag = $urandom_range(1, 3);
      for (i = 0; i < nfrag; i++) begin
        frame(i == nfrag - 1,
              (i != 0) ? wsd_pkg::OP_CONT : (r < 45) ? wsd_pkg::OP_TEXT : wsd_pkg::OP_BINARY,
              1'b0, pick_len());
        if (i != nfrag - 1 && $urandom_range(3) == 0) control_frame();
      end
    end else if (r < 72) begin
      control_frame();
    end else if (r < 80) begin
      frame(1'($urandom_range(1)), 4'($urandom_range(15)), 1'b1, pick_len());
    end else if (r < 87) begin
      frame(1'($urandom_range(1)), wsd_pkg::OP_CONT, 1'b0, pick_len());
    end else begin
      frame(1'($urandom_range(1)), 4'($urandom_range(15)), 1'($urandom_range(1)),
            pick_len());
    end
  endtask

  task automatic directed_frames();
    frame(1'b1, wsd_pkg::OP_TEXT, 1'b0, 0);
    frame(1'b1, wsd_pkg::OP_TEXT, 1'b0, 3);
    // fragmented text with a non-final ping in the middle and an empty last fragment
    frame(1'b0, wsd_pkg::OP_TEXT, 1'b0, 2);
    frame(1'b0, wsd_pkg::OP_PING, 1'b0, 0);
    frame(1'b0, wsd_pkg::OP_CONT, 1'b0, 1);
    frame(1'b1, wsd_pkg::OP_CONT, 1'b0, 0);
    frame(1'b1, wsd_pkg::OP_CLOSE, 1'b0, 0);
    frame(1'b1, wsd_pkg::OP_CLOSE, 1'b0, 1);
    send_frame(1'b1, wsd_pkg::OP_CLOSE, 1'b0, 64'd2, 2, LEN_SHORT, 8'hFF);
    send_frame(1'b1, wsd_pkg::OP_CLOSE, 1'b0, 64'd2, 2, LEN_SHORT, 8'h00);
    frame(1'b1, wsd_pkg::OP_CLOSE, 1'b0, 4);
    frame(1'b0, wsd_pkg::OP_PING, 1'b0, 2);
    frame(1'b1, wsd_pkg::OP_TEXT, 1'b1, 2);
    frame(1'b0, wsd_pkg::OP_PING, 1'b1, 0);
    frame(1'b1, wsd_pkg::OP_CONT, 1'b0, 1);
    // binary message replaced by a new text message
    frame(1'b0, wsd_pkg::OP_BINARY, 1'b0, 2);
    frame(1'b1, wsd_pkg::OP_TEXT, 1'b0, 1);
    frame(1'b1, OP_PONG, 1'b0, 1);
    frame(1'b1, OP_RSV_DATA, 1'b0, 1);
    frame(1'b0, OP_RSV_CTRL, 1'b0, 0);
    send_frame(1'b1, wsd_pkg::OP_TEXT, 1'b0, 64'd5, 5, LEN_16, FILL_RANDOM);
    send_frame(1'b1, wsd_pkg::OP_TEXT, 1'b0, 64'd2, 2, LEN_64, FILL_RANDOM);
    send_frame(1'b1, wsd_pkg::OP_BINARY, 1'b0, 64'd125, 125, LEN_SHORT, FILL_RANDOM);
    // final binary frame ends the text message, so the continuation is stray
    frame(1'b0, wsd_pkg::OP_TEXT, 1'b0, 1);
    frame(1'b1, wsd_pkg::OP_BINARY, 1'b0, 1);
    frame(1'b1, wsd_pkg::OP_CONT, 1'b0, 1);
  endtask

  initial begin
    int ph;
    int target;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_frames();
    drain();
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct <= 0;  snk_stall_pct <= 0;  end
        1: begin src_idle_pct <= 48; snk_stall_pct <= 0;  end
        2: begin src_idle_pct <= 0;  snk_stall_pct <= 48; end
        default: begin src_idle_pct <= 26; snk_stall_pct <= 26; end
      endcase
      @(posedge clk);
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) random_frame();
      drain();
    end
    // a text frame whose 64-bit length has its top bit set never ends
    send_frame(1'b1, wsd_pkg::OP_TEXT, 1'b0, 64'h8000_0000_0000_0010, 24, LEN_64,
               FILL_RANDOM);
    drain();
    repeat (10) @(posedge clk);
    $display("tb: %0d bytes in frames of every opcode, all length encodings, masked and not",
             bytes_sent);
    $display("tb: %0d events compared, kinds seen (masked..text) %b", checked, kinds_seen);
    if (fail_count == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
hdl/wsd_pkg.sv
hdl/wsd_parse.sv
hdl/websocket_frame_deframer.sv
verif/wsd_event_checker.sv
verif/tb_websocket_frame_deframer.sv
